>>> design/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg: shared definitions for the first-fit hole allocator
// Request and status codes, default sizes and the cell control bundle.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int HOLE_ENTRIES = 128;
  localparam int CLICK_BITS   = 20;

  // request kinds
  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_MAX   = 2'd2;

  // result status
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_NO_MEM = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;

  // scan load flavor
  localparam logic [1:0] LD_ALLOC = 2'd0;
  localparam logic [1:0] LD_FREE  = 2'd1;
  localparam logic [1:0] LD_MAX   = 2'd2;

  // action at the cell that holds the found position
  localparam logic [1:0] PM_KEEP = 2'd0;
  localparam logic [1:0] PM_WR   = 2'd1;
  localparam logic [1:0] PM_SHL  = 2'd2;

  // action at cells past the found position
  localparam logic [1:0] TM_KEEP = 2'd0;
  localparam logic [1:0] TM_SHL  = 2'd1;
  localparam logic [1:0] TM_SHR  = 2'd2;

  typedef struct packed {
    logic       load;
    logic [1:0] load_mode;
    logic       scan;
    logic       scan_max;
    logic       apply;
    logic       wr_pred;
    logic [1:0] pos_mode;
    logic [1:0] tail_mode;
    logic       wr_next;
  } cell_ctl_t;

endpackage

>>> design/first_fit_hole_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_hole_allocator_core: first-fit hole list with coalescing
// Sorted row of hole cells; allocate, free with merge, and largest-hole query.
// ----------------------------------------------------------------------------
// Flow: load, prefix scan for the first fit, decide, apply, then a second
//   load and prefix scan across the row for the largest hole, and done.
// One request at a time; the next transfer is taken only after the result
//   is handed to the output register, which out_stall_i can hold.
// Reset clears the hole count and control; hole contents are never read
//   beyond the count, so they are not cleared.
module first_fit_hole_allocator_core #(
  parameter int HoleEntries = ffha_pkg::HOLE_ENTRIES,
  parameter int ClickBits   = ffha_pkg::CLICK_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           func_i,
  input  logic [ClickBits-1:0]                 block_base_i,
  input  logic [ClickBits:0]                   block_clicks_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [ClickBits-1:0]                 granted_base_o,
  output logic [ClickBits:0]                   largest_hole_o,
  output logic [1:0]                           status_o,
  output logic [$clog2(HoleEntries+1)-1:0]     holes_used_o
);

  localparam int AW        = ClickBits;
  localparam int LW        = ClickBits + 1;
  localparam int XW        = ClickBits + 2;
  localparam int CW        = $clog2(HoleEntries + 1);
  localparam int DW        = 1 + AW + LW;
  localparam int SW        = 3 * DW + 2;
  localparam int ScanSteps = $clog2(HoleEntries);
  localparam int StW       = (ScanSteps > 1) ? $clog2(ScanSteps) : 1;

  // controller states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_APPLY  = 3'd4;
  localparam logic [2:0] S_MLOAD  = 3'd5;
  localparam logic [2:0] S_MSCAN  = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  typedef struct packed {
    logic          v;
    logic [AW-1:0] s;
    logic [LW-1:0] l;
  } dat_t;

  typedef struct packed {
    logic f;
    dat_t fd;
    logic pv;
    dat_t pd;
    dat_t last;
  } scan_t;

  logic [2:0]     state_q, state_d;
  logic [StW-1:0] step_q, step_d;
  logic [CW-1:0]  cnt_q, cnt_nx_q, cnt_nx_d;
  logic           in_xfer;

  // request held for the whole operation
  logic [1:0]    func_q;
  logic [AW-1:0] base_q;
  logic [LW-1:0] clicks_q;
  logic [LW-1:0] flen_q;
  logic [LW-1:0] span;

  // decision registered for the apply cycle
  logic [AW-1:0] v0_start_q, v0_start_d, v1_start_q, v1_start_d;
  logic [LW-1:0] v0_len_q, v0_len_d, v1_len_q, v1_len_d;
  logic          wr_pred_q, wr_pred_d, wr_next_q, wr_next_d;
  logic [1:0]    pos_mode_q, pos_mode_d, tail_mode_q, tail_mode_d;
  logic [AW-1:0] grant_q, grant_d;
  logic [1:0]    status_q, status_d;

  logic                out_valid_q;
  logic [AW-1:0]       out_base_q;
  logic [LW-1:0]       out_len_q;
  logic [1:0]          out_status_q;
  logic [CW-1:0]       out_cnt_q;

  ffha_pkg::cell_ctl_t ctl;

  logic [HoleEntries-1:0][SW-1:0]                scan_w;
  logic [HoleEntries-1:0][ScanSteps-1:0][SW-1:0] scan_src_w;
  logic [HoleEntries-1:0][AW-1:0]                start_w;
  logic [HoleEntries-1:0][LW-1:0]                len_w;
  logic [HoleEntries-1:0]                        f_w, first_w;

  scan_t g;
  assign g = scan_t'(scan_w[HoleEntries-1]);

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // room from the block base to the top of the address space
  assign span = {1'b1, {AW{1'b0}}} - LW'(block_base_i);

  // --------------------------------------------------------------------------
  // Cell row
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < HoleEntries; i++) begin : g_cell
    for (genvar k = 0; k < ScanSteps; k++) begin : g_src
      if (i >= (1 << k)) begin : g_link
        assign scan_src_w[i][k] = scan_w[i - (1 << k)];
      end else begin : g_none
        assign scan_src_w[i][k] = '0;
      end
    end

    logic [AW-1:0] prev_s, next_s;
    logic [LW-1:0] prev_l, next_l;
    logic          f_prev, first_prev, first_next;

    if (i == 0) begin : g_head
      assign prev_s     = '0;
      assign prev_l     = '0;
      assign f_prev     = 1'b0;
      assign first_prev = 1'b0;
    end else begin : g_body
      assign prev_s     = start_w[i-1];
      assign prev_l     = len_w[i-1];
      assign f_prev     = f_w[i-1];
      assign first_prev = first_w[i-1];
    end

    if (i == HoleEntries - 1) begin : g_tail
      assign next_s     = start_w[i];
      assign next_l     = len_w[i];
      assign first_next = 1'b0;
    end else begin : g_mid
      assign next_s     = start_w[i+1];
      assign next_l     = len_w[i+1];
      assign first_next = first_w[i+1];
    end

    ffha_cell #(
      .ClickBits  (ClickBits),
      .HoleEntries(HoleEntries),
      .CellIdx    (i),
      .ScanSteps  (ScanSteps),
      .StW        (StW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .step_i      (step_q),
      .cnt_i       (cnt_q),
      .base_i      (base_q),
      .clicks_i    (clicks_q),
      .v0_start_i  (v0_start_q),
      .v0_len_i    (v0_len_q),
      .v1_start_i  (v1_start_q),
      .v1_len_i    (v1_len_q),
      .prev_start_i(prev_s),
      .prev_len_i  (prev_l),
      .next_start_i(next_s),
      .next_len_i  (next_l),
      .f_prev_i    (f_prev),
      .first_prev_i(first_prev),
      .first_next_i(first_next),
      .scan_src_i  (scan_src_w[i]),
      .scan_o      (scan_w[i]),
      .start_o     (start_w[i]),
      .len_o       (len_w[i]),
      .f_o         (f_w[i]),
      .first_o     (first_w[i])
    );
  end

  // --------------------------------------------------------------------------
  // Cell control from the current state
  // --------------------------------------------------------------------------
  always_comb begin
    ctl           = '0;
    ctl.load      = (state_q == S_LOAD) || (state_q == S_MLOAD);
    ctl.scan      = (state_q == S_SCAN) || (state_q == S_MSCAN);
    ctl.scan_max  = (state_q == S_MSCAN);
    ctl.apply     = (state_q == S_APPLY);
    ctl.wr_pred   = wr_pred_q;
    ctl.wr_next   = wr_next_q;
    ctl.pos_mode  = pos_mode_q;
    ctl.tail_mode = tail_mode_q;
    if (state_q == S_MLOAD) begin
      ctl.load_mode = ffha_pkg::LD_MAX;
    end else if (func_q == ffha_pkg::FUNC_FREE) begin
      ctl.load_mode = ffha_pkg::LD_FREE;
    end else begin
      ctl.load_mode = ffha_pkg::LD_ALLOC;
    end
  end

  // --------------------------------------------------------------------------
  // Decide: the scan result at the last cell gives the first hit, the entry
  // just before it, and (for a free at the front) cells 0 and 1 directly.
  // --------------------------------------------------------------------------
  logic [XW-1:0] pend, bend, o1_start_x;
  logic [LW-1:0] alloc_left;
  logic [AW:0]   alloc_start;
  logic          o1_v, m1, m2, j2, j3;

  assign pend        = XW'(g.pd.s) + XW'(g.pd.l);
  assign bend        = XW'(base_q) + XW'(flen_q);
  assign o1_start_x  = XW'(start_w[1]);
  assign o1_v        = int'(cnt_q) >= 2;
  assign m1          = g.pv && (pend == XW'(base_q));
  assign m2          = g.fd.v && (bend == XW'(g.fd.s));
  assign j2          = m2 && o1_v && ((bend + XW'(g.fd.l)) == o1_start_x);
  assign j3          = !m2 && o1_v && ((XW'(g.fd.s) + XW'(g.fd.l)) == o1_start_x);
  assign alloc_left  = g.fd.l - clicks_q;
  assign alloc_start = (AW+1)'(g.fd.s) + (AW+1)'(clicks_q);

  always_comb begin
    v0_start_d  = base_q;
    v0_len_d    = flen_q;
    v1_start_d  = g.fd.s;
    v1_len_d    = LW'(g.fd.l + len_w[1]);
    wr_pred_d   = 1'b0;
    wr_next_d   = 1'b0;
    pos_mode_d  = ffha_pkg::PM_KEEP;
    tail_mode_d = ffha_pkg::TM_KEEP;
    grant_d     = '0;
    status_d    = ffha_pkg::STAT_OK;
    cnt_nx_d    = cnt_q;
    case (func_q)
      ffha_pkg::FUNC_ALLOC: begin
        if (g.f) begin
          grant_d = g.fd.s;
          if (alloc_left == '0) begin
            pos_mode_d  = ffha_pkg::PM_SHL;
            tail_mode_d = ffha_pkg::TM_SHL;
            cnt_nx_d    = cnt_q - CW'(1);
          end else begin
            pos_mode_d = ffha_pkg::PM_WR;
            v0_start_d = alloc_start[AW-1:0];
            v0_len_d   = alloc_left;
          end
        end else begin
          status_d = ffha_pkg::STAT_NO_MEM;
        end
      end
      ffha_pkg::FUNC_FREE: begin
        if (clicks_q == '0) begin
          status_d = ffha_pkg::STAT_OK;
        end else if (int'(cnt_q) >= HoleEntries) begin
          status_d = ffha_pkg::STAT_FULL;
        end else if (g.pv) begin
          // insertion point has a predecessor
          if (m1 && m2) begin
            wr_pred_d   = 1'b1;
            v0_start_d  = g.pd.s;
            v0_len_d    = LW'(g.pd.l + flen_q + g.fd.l);
            pos_mode_d  = ffha_pkg::PM_SHL;
            tail_mode_d = ffha_pkg::TM_SHL;
            cnt_nx_d    = cnt_q - CW'(1);
          end else if (m1) begin
            wr_pred_d  = 1'b1;
            v0_start_d = g.pd.s;
            v0_len_d   = LW'(g.pd.l + flen_q);
          end else if (m2) begin
            pos_mode_d = ffha_pkg::PM_WR;
            v0_len_d   = LW'(flen_q + g.fd.l);
          end else begin
            pos_mode_d  = ffha_pkg::PM_WR;
            tail_mode_d = ffha_pkg::TM_SHR;
            cnt_nx_d    = cnt_q + CW'(1);
          end
        end else begin
          // insertion at the front: old entries 0 and 1 may join
          pos_mode_d = ffha_pkg::PM_WR;
          if (j2) begin
            v0_len_d    = LW'(flen_q + g.fd.l + len_w[1]);
            tail_mode_d = ffha_pkg::TM_SHL;
            cnt_nx_d    = cnt_q - CW'(1);
          end else if (m2) begin
            v0_len_d = LW'(flen_q + g.fd.l);
          end else if (j3) begin
            wr_next_d = 1'b1;
          end else begin
            tail_mode_d = ffha_pkg::TM_SHR;
            cnt_nx_d    = cnt_q + CW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        step_d  = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        step_d = step_q + StW'(1);
        if (step_q == StW'(ScanSteps - 1)) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: state_d = S_APPLY;
      S_APPLY:  state_d = S_MLOAD;
      S_MLOAD: begin
        step_d  = '0;
        state_d = S_MSCAN;
      end
      S_MSCAN: begin
        step_d = step_q + StW'(1);
        if (step_q == StW'(ScanSteps - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      wr_pred_q   <= 1'b0;
      wr_next_q   <= 1'b0;
      pos_mode_q  <= ffha_pkg::PM_KEEP;
      tail_mode_q <= ffha_pkg::TM_KEEP;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (state_q == S_DECIDE) begin
        wr_pred_q   <= wr_pred_d;
        wr_next_q   <= wr_next_d;
        pos_mode_q  <= pos_mode_d;
        tail_mode_q <= tail_mode_d;
      end
      if (state_q == S_APPLY) begin
        cnt_q <= cnt_nx_q;
      end
      if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      func_q   <= func_i;
      base_q   <= block_base_i;
      clicks_q <= block_clicks_i;
      // clip the block so it ends no higher than the top of the address space
      flen_q   <= (block_clicks_i > span) ? span : block_clicks_i;
    end
    if (state_q == S_DECIDE) begin
      v0_start_q <= v0_start_d;
      v0_len_q   <= v0_len_d;
      v1_start_q <= v1_start_d;
      v1_len_q   <= v1_len_d;
      grant_q    <= grant_d;
      status_q   <= status_d;
      cnt_nx_q   <= cnt_nx_d;
    end
    if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
      out_base_q   <= grant_q;
      out_len_q    <= g.fd.l;
      out_status_q <= status_q;
      out_cnt_q    <= cnt_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign granted_base_o = out_base_q;
  assign largest_hole_o = out_len_q;
  assign status_o       = out_status_q;
  assign holes_used_o   = out_cnt_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= HoleEntries)
    else $error("hole count beyond table size");

  a_cnt_only_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> ($past(state_q) == S_APPLY))
    else $error("hole count changed outside apply");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result raised outside done");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && status_q == ffha_pkg::STAT_FULL) |->
      (int'(cnt_q) == HoleEntries))
    else $error("table full reported with free entries");

endmodule

>>> design/ffha_cell.sv
// ----------------------------------------------------------------------------
// ffha_cell: one hole entry of the table
// Holds one hole, takes part in the prefix scan and shifts with its neighbors.
// ----------------------------------------------------------------------------
module ffha_cell #(
  parameter int ClickBits   = ffha_pkg::CLICK_BITS,
  parameter int HoleEntries = ffha_pkg::HOLE_ENTRIES,
  parameter int CellIdx     = 0,
  parameter int ScanSteps   = 1,
  parameter int StW         = 1
) (
  input  logic                                         clk_i,
  input  ffha_pkg::cell_ctl_t                          ctl_i,
  input  logic [StW-1:0]                               step_i,
  input  logic [$clog2(HoleEntries+1)-1:0]             cnt_i,
  input  logic [ClickBits-1:0]                         base_i,
  input  logic [ClickBits:0]                           clicks_i,
  input  logic [ClickBits-1:0]                         v0_start_i,
  input  logic [ClickBits:0]                           v0_len_i,
  input  logic [ClickBits-1:0]                         v1_start_i,
  input  logic [ClickBits:0]                           v1_len_i,
  input  logic [ClickBits-1:0]                         prev_start_i,
  input  logic [ClickBits:0]                           prev_len_i,
  input  logic [ClickBits-1:0]                         next_start_i,
  input  logic [ClickBits:0]                           next_len_i,
  input  logic                                         f_prev_i,
  input  logic                                         first_prev_i,
  input  logic                                         first_next_i,
  input  logic [ScanSteps-1:0][3*(2*ClickBits+2)+1:0]  scan_src_i,
  output logic [3*(2*ClickBits+2)+1:0]                 scan_o,
  output logic [ClickBits-1:0]                         start_o,
  output logic [ClickBits:0]                           len_o,
  output logic                                         f_o,
  output logic                                         first_o
);

  typedef struct packed {
    logic                 v;
    logic [ClickBits-1:0] s;
    logic [ClickBits:0]   l;
  } dat_t;

  typedef struct packed {
    logic f;
    dat_t fd;
    logic pv;
    dat_t pd;
    dat_t last;
  } scan_t;

  logic [ClickBits-1:0] start_q, start_d;
  logic [ClickBits:0]   len_q, len_d;
  scan_t                scan_q, scan_d;
  scan_t                src, cmb, mx, ld;
  logic                 valid, use_src, is_pos;

  assign valid   = CellIdx < int'(cnt_i);
  assign src     = scan_t'(scan_src_i[step_i]);
  assign use_src = CellIdx >= (1 << step_i);
  assign is_pos  = scan_q.f & ~f_prev_i;

  // combine the segment to the left with our own segment
  always_comb begin
    cmb = scan_q;
    if (src.f) begin
      cmb.f  = 1'b1;
      cmb.fd = src.fd;
      cmb.pv = src.pv;
      cmb.pd = src.pd;
    end else begin
      cmb.pv = 1'b1;
      cmb.pd = scan_q.pv ? scan_q.pd : src.last;
    end
    mx = scan_q;
    if (src.fd.l > scan_q.fd.l) begin
      mx.fd.l = src.fd.l;
    end
  end

  always_comb begin
    ld.fd.v = valid;
    ld.fd.s = start_q;
    ld.fd.l = len_q;
    case (ctl_i.load_mode)
      ffha_pkg::LD_ALLOC: begin
        ld.f = valid && (len_q >= clicks_i);
      end
      ffha_pkg::LD_FREE: begin
        ld.f = !valid || (start_q >= base_i);
      end
      default: begin
        ld.f = 1'b0;
        if (!valid) begin
          ld.fd.l = '0;
        end
      end
    endcase
    ld.pv   = 1'b0;
    ld.pd   = '0;
    ld.last = ld.fd;
  end

  always_comb begin
    scan_d = scan_q;
    if (ctl_i.load) begin
      scan_d = ld;
    end else if (ctl_i.scan && use_src) begin
      scan_d = ctl_i.scan_max ? mx : cmb;
    end
  end

  always_comb begin
    start_d = start_q;
    len_d   = len_q;
    if (ctl_i.apply) begin
      if (first_next_i && ctl_i.wr_pred) begin
        start_d = v0_start_i;
        len_d   = v0_len_i;
      end else if (is_pos) begin
        case (ctl_i.pos_mode)
          ffha_pkg::PM_WR: begin
            start_d = v0_start_i;
            len_d   = v0_len_i;
          end
          ffha_pkg::PM_SHL: begin
            start_d = next_start_i;
            len_d   = next_len_i;
          end
          default: ;
        endcase
      end else if (first_prev_i && ctl_i.wr_next) begin
        start_d = v1_start_i;
        len_d   = v1_len_i;
      end else if (f_prev_i) begin
        case (ctl_i.tail_mode)
          ffha_pkg::TM_SHL: begin
            start_d = next_start_i;
            len_d   = next_len_i;
          end
          ffha_pkg::TM_SHR: begin
            start_d = prev_start_i;
            len_d   = prev_len_i;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    len_q   <= len_d;
    scan_q  <= scan_d;
  end

  assign scan_o  = scan_q;
  assign start_o = start_q;
  assign len_o   = len_q;
  assign f_o     = scan_q.f;
  assign first_o = is_pos;

endmodule
